/* sv/rv32im_pkg.sv */
// Shared types and constants for the RV32IM execute block.
package rv32im_pkg;

   localparam int XLEN = 32;
   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = 5;
   localparam logic [XLEN-1:0] RESET_VECTOR_DEFAULT = 32'h8000_0000;

   localparam logic [11:0] CSR_MTVEC = 12'd773;
   localparam logic [11:0] CSR_MSTATUS = 12'd768;
   localparam logic [11:0] CSR_MEPC = 12'd833;
   localparam logic [11:0] CSR_MCAUSE = 12'd834;
   localparam logic [REG_IDX_W-1:0] REG_A7 = 5'd17;
   localparam logic [REG_IDX_W-1:0] REG_A0 = 5'd10;

   localparam logic [6:0] OP_LUI = 7'h37;
   localparam logic [6:0] OP_AUIPC = 7'h17;
   localparam logic [6:0] OP_JAL = 7'h6F;
   localparam logic [6:0] OP_JALR = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD = 7'h03;
   localparam logic [6:0] OP_STORE = 7'h23;
   localparam logic [6:0] OP_IMM = 7'h13;
   localparam logic [6:0] OP_REG = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [31:0] INSTR_ECALL = 32'h0000_0073;
   localparam logic [31:0] INSTR_MRET = 32'h3020_0073;
   localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;

   localparam logic REQ_EXEC = 1'b0;
   localparam logic REQ_LOAD_RET = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_HALT = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [31:0] instr_word;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        mem_read;
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] mem_wdata;
      logic [1:0]  status;
      logic [31:0] halt_code;
      logic [4:0]  wb_reg;
      logic [31:0] wb_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_WB,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic        is_signed;
      logic        want_rem;
   } div_ctl_type;

endpackage

/* sv/rv32im_div.sv */
// Iterative radix-2 divider for the RV32IM execute block.
module rv32im_div (
   input  logic                     clock,
   input  logic                     reset,
   input  rv32im_pkg::div_ctl_type  ctl,
   input  logic [31:0]              dividend,
   input  logic [31:0]              divisor,
   output logic                     done,
   output logic [31:0]              result
);
   import rv32im_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic        rem_sel_ff, rem_sel_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic [31:0] qa, qb, qfix, rfix;

   always_comb begin
      qa = (ctl.is_signed && dividend[31]) ? 32'd0 - dividend : dividend;
      qb = (ctl.is_signed && divisor[31]) ? 32'd0 - divisor : divisor;
      shifted = {rem_ff[31:0], quo_ff[31]};
      diff = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      rem_sel_in = rem_sel_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         quo_in = qa;
         rem_in = 33'd0;
         dvs_in = qb;
         negq_in = ctl.is_signed && (dividend[31] ^ divisor[31]);
         negr_in = ctl.is_signed && dividend[31];
         rem_sel_in = ctl.want_rem;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      rem_sel_ff <= rem_sel_in;
   end

   // zero divisor: quotient all ones, remainder = dividend (falls out of the loop,
   // signed case sign-fixed to spec by keeping negation of the negated magnitude)
   always_comb begin
      qfix = negq_ff ? 32'd0 - quo_ff : quo_ff;
      rfix = negr_ff ? 32'd0 - rem_ff[31:0] : rem_ff[31:0];
      if (dvs_ff == 32'd0) qfix = 32'hFFFF_FFFF;
   end

   assign done = done_ff;
   assign result = rem_sel_ff ? rfix : qfix;

endmodule

/* sv/rv32im_instruction_execute_top.sv */
// Top level of the RV32IM execute block: register file memory, CSRs and sequencer.
// One transaction is taken at a time. A transaction passes from acceptance to a valid result
// through register file read, execute with writeback and output, and the block is ready
// again after the result is taken. Divide and remainder, but for the signed overflow case,
// pass through the radix-2 divider and a writeback state between execute and output.
// Rate is set by the registered read of the register file memory, the divider loop and
// output back-pressure. The register file is cleared after reset by a pass over every
// register, during which no transaction is accepted.
module rv32im_instruction_execute_top #(
   parameter logic [31:0] RESET_VECTOR = rv32im_pkg::RESET_VECTOR_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rv32im_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rv32im_pkg::rsp_type  rsp_data,
   input  logic                 csr_we,
   input  logic [31:0]          csr_wdata
);
   import rv32im_pkg::*;

   logic [31:0] regs [REG_COUNT];
   logic [31:0] rs1_rd_ff, rs2_rd_ff, a0_rd_ff, a7_rd_ff;

   state_type   state_ff, state_in;
   logic [31:0] rvec_ff;
   logic [31:0] pc_ff, pc_in;
   logic [31:0] mtvec_ff, mtvec_in, mstatus_ff, mstatus_in;
   logic [31:0] mepc_ff, mepc_in, mcause_ff, mcause_in;
   logic [8:0]  pend_ff, pend_in;
   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        clr_ff;
   logic [REG_IDX_W-1:0] clr_idx_ff;
   logic [REG_IDX_W:0]   clr_cnt_in;
   logic [REG_IDX_W:0]   clr_cnt_ff;

   logic        we;
   logic [REG_IDX_W-1:0] waddr;
   logic [31:0] wdata;
   logic        accept;

   logic [31:0] w, a, b, pc;
   logic [6:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rd;
   logic [31:0] ii, is, ib, ij;
   logic signed [32:0] mul_sa, mul_sb;
   logic signed [65:0] mul_prod;
   logic [31:0] mul_res_in;
   div_ctl_type div_ctl;
   logic        div_done;
   logic [31:0] div_result;
   logic [31:0] div_a, div_b;
   logic        div_special;
   logic [31:0] div_special_val;

   assign accept = req_valid && req_ready;
   assign w = req_ff.instr_word;
   assign op = w[6:0];
   assign f3 = w[14:12];
   assign f7 = w[31:25];
   assign rd = w[11:7];
   assign a = rs1_rd_ff;
   assign b = rs2_rd_ff;
   assign pc = pc_ff;
   assign ii = {{20{w[31]}}, w[31:20]};
   assign is = {{20{w[31]}}, w[31:25], w[11:7]};
   assign ib = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign ij = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

   always_ff @(posedge clock) begin
      if (we) regs[waddr] <= wdata;
      rs1_rd_ff <= regs[w[19:15]];
      rs2_rd_ff <= regs[w[24:20]];
      a0_rd_ff <= regs[REG_A0];
      a7_rd_ff <= regs[REG_A7];
   end

   assign mul_sa = {(f3[1:0] != 2'd3) && a[31], a};
   assign mul_sb = {(f3[1:0] == 2'd1) && b[31], b};
   assign mul_prod = mul_sa * mul_sb;

   always_comb begin
      case (f3[1:0])
         2'd0: mul_res_in = mul_prod[31:0];
         default: mul_res_in = mul_prod[63:32];
      endcase
   end

   assign div_a = a;
   assign div_b = b;
   assign div_special = !f3[0] && (b != 32'd0) && (a == 32'h8000_0000)
                        && (b == 32'hFFFF_FFFF);
   assign div_special_val = f3[1] ? 32'd0 : a;

   rv32im_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .result   (div_result)
   );

   always_comb begin
      logic        ok, wr, t;
      logic [31:0] rv, npc;
      logic [31:0] old;
      logic        hit;
      logic [31:0] d;
      ok = 1'b1;
      wr = 1'b0;
      t = 1'b0;
      rv = 32'd0;
      npc = pc + 32'd4;
      old = 32'd0;
      hit = 1'b0;
      d = 32'd0;
      state_in = state_ff;
      pc_in = pc_ff;
      mtvec_in = mtvec_ff;
      mstatus_in = mstatus_ff;
      mepc_in = mepc_ff;
      mcause_in = mcause_ff;
      pend_in = pend_ff;
      rsp_in = rsp_ff;
      we = 1'b0;
      waddr = clr_idx_ff;
      wdata = 32'd0;
      div_ctl = '0;
      req_ready = (state_ff == ST_IDLE) && !clr_ff;
      if (clr_ff) we = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_in = '0;
            rsp_in.next_pc = pc;
            state_in = ST_OUT;
            if (req_ff.opcode == REQ_LOAD_RET) begin
               if (pend_ff[8]) begin
                  case (pend_ff[7:5])
                     3'd0: d = {{24{req_ff.load_data[7]}}, req_ff.load_data[7:0]};
                     3'd1: d = {{16{req_ff.load_data[15]}}, req_ff.load_data[15:0]};
                     3'd4: d = {24'd0, req_ff.load_data[7:0]};
                     3'd5: d = {16'd0, req_ff.load_data[15:0]};
                     default: d = req_ff.load_data;
                  endcase
                  pend_in = '0;
                  if (pend_ff[4:0] != 5'd0) begin
                     we = 1'b1;
                     waddr = pend_ff[4:0];
                     wdata = d;
                     rsp_in.wb_reg = pend_ff[4:0];
                     rsp_in.wb_value = d;
                  end
               end
            end else if (!pend_ff[8]) begin
               case (op)
                  OP_LUI: begin rv = {w[31:12], 12'd0}; wr = 1'b1; end
                  OP_AUIPC: begin rv = pc + {w[31:12], 12'd0}; wr = 1'b1; end
                  OP_JAL: begin rv = pc + 32'd4; wr = 1'b1; npc = pc + ij; end
                  OP_JALR: begin
                     if (f3 != 3'd0) ok = 1'b0;
                     else begin
                        rv = pc + 32'd4; wr = 1'b1;
                        npc = (a + ii) & ~32'd1;
                     end
                  end
                  OP_BRANCH: begin
                     case (f3)
                        3'd0: t = a == b;
                        3'd1: t = a != b;
                        3'd4: t = $signed(a) < $signed(b);
                        3'd5: t = !($signed(a) < $signed(b));
                        3'd6: t = a < b;
                        3'd7: t = a >= b;
                        default: ok = 1'b0;
                     endcase
                     if (t) npc = pc + ib;
                  end
                  OP_LOAD: begin
                     if (f3 == 3'd3 || f3 > 3'd5) ok = 1'b0;
                     else begin
                        rsp_in.mem_read = 1'b1;
                        rsp_in.mem_addr = a + ii;
                        rsp_in.mem_size = {1'b0, f3[0]} | {f3[1], 1'b0};
                        pend_in = {1'b1, f3, rd};
                     end
                  end
                  OP_STORE: begin
                     if (f3 > 3'd2) ok = 1'b0;
                     else begin
                        rsp_in.mem_write = 1'b1;
                        rsp_in.mem_addr = a + is;
                        rsp_in.mem_size = f3[1:0];
                        rsp_in.mem_wdata = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                           (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                     end
                  end
                  OP_IMM: begin
                     wr = 1'b1;
                     case (f3)
                        3'd0: rv = a + ii;
                        3'd2: rv = {31'd0, $signed(a) < $signed(ii)};
                        3'd3: rv = {31'd0, a < ii};
                        3'd4: rv = a ^ ii;
                        3'd6: rv = a | ii;
                        3'd7: rv = a & ii;
                        3'd1: begin
                           if (f7 == 7'd0) rv = a << ii[4:0];
                           else ok = 1'b0;
                        end
                        default: begin
                           if (f7 == 7'd0) rv = a >> ii[4:0];
                           else if (f7 == 7'h20) rv = $unsigned($signed(a) >>> ii[4:0]);
                           else ok = 1'b0;
                        end
                     endcase
                  end
                  OP_REG: begin
                     wr = 1'b1;
                     if (f7 == 7'd1) begin
                        if (!f3[2]) rv = mul_res_in;
                        else if (div_special) rv = div_special_val;
                        else begin
                           div_ctl.start = 1'b1;
                           div_ctl.is_signed = !f3[0];
                           div_ctl.want_rem = f3[1];
                           state_in = ST_DIV;
                        end
                     end else if (f7 == 7'h20) begin
                        if (f3 == 3'd0) rv = a - b;
                        else if (f3 == 3'd5) rv = $unsigned($signed(a) >>> b[4:0]);
                        else ok = 1'b0;
                     end else if (f7 == 7'd0) begin
                        case (f3)
                           3'd0: rv = a + b;
                           3'd1: rv = a << b[4:0];
                           3'd2: rv = {31'd0, $signed(a) < $signed(b)};
                           3'd3: rv = {31'd0, a < b};
                           3'd4: rv = a ^ b;
                           3'd5: rv = a >> b[4:0];
                           3'd6: rv = a | b;
                           default: rv = a & b;
                        endcase
                     end else ok = 1'b0;
                  end
                  OP_SYSTEM: begin
                     if (f3 == 3'd1 || f3 == 3'd2) begin
                        hit = 1'b1;
                        case (w[31:20])
                           CSR_MTVEC: old = mtvec_ff;
                           CSR_MSTATUS: old = mstatus_ff;
                           CSR_MEPC: old = mepc_ff;
                           CSR_MCAUSE: old = mcause_ff;
                           default: hit = 1'b0;
                        endcase
                        if (hit) begin
                           case (w[31:20])
                              CSR_MTVEC: mtvec_in = f3[0] ? a : (old | a);
                              CSR_MSTATUS: mstatus_in = f3[0] ? a : (old | a);
                              CSR_MEPC: mepc_in = f3[0] ? a : (old | a);
                              default: mcause_in = f3[0] ? a : (old | a);
                           endcase
                        end
                        rv = old; wr = 1'b1;
                     end else if (w == INSTR_ECALL) begin
                        mepc_in = pc + 32'd4;
                        mcause_in = a7_rd_ff;
                        npc = mtvec_ff;
                     end else if (w == INSTR_MRET) begin
                        npc = mepc_ff;
                     end else if (w == INSTR_EBREAK) begin
                        rsp_in.status = STATUS_HALT;
                        rsp_in.halt_code = a0_rd_ff;
                     end else ok = 1'b0;
                  end
                  default: ok = 1'b0;
               endcase
               if (!ok) begin
                  rsp_in = '0;
                  rsp_in.status = STATUS_INVALID;
                  npc = pc + 32'd4;
                  wr = 1'b0;
                  pend_in = pend_ff;
                  mtvec_in = mtvec_ff;
                  mstatus_in = mstatus_ff;
                  mepc_in = mepc_ff;
                  mcause_in = mcause_ff;
                  state_in = ST_OUT;
                  div_ctl = '0;
               end
               pc_in = npc;
               rsp_in.next_pc = npc;
               if (wr && rd != 5'd0 && state_in != ST_DIV) begin
                  we = 1'b1;
                  waddr = rd;
                  wdata = rv;
                  rsp_in.wb_reg = rd;
                  rsp_in.wb_value = rv;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_WB;
               if (rd != 5'd0) begin
                  rsp_in.wb_reg = rd;
                  rsp_in.wb_value = div_result;
               end
            end
         end
         ST_WB: begin
            if (rsp_ff.wb_reg != 5'd0) begin
               we = 1'b1;
               waddr = rsp_ff.wb_reg;
               wdata = rsp_ff.wb_value;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign clr_cnt_in = clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= rvec_ff;
         mtvec_ff <= '0;
         mstatus_ff <= '0;
         mepc_ff <= '0;
         mcause_ff <= '0;
         pend_ff <= '0;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         mtvec_ff <= mtvec_in;
         mstatus_ff <= mstatus_in;
         mepc_ff <= mepc_in;
         mcause_ff <= mcause_in;
         pend_ff <= pend_in;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_in;
            if (clr_cnt_in[REG_IDX_W]) clr_ff <= 1'b0;
         end
      end
      if (accept) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign clr_idx_ff = clr_cnt_ff[REG_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) rvec_ff <= RESET_VECTOR;
      else if (csr_we) rvec_ff <= csr_wdata;
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = rsp_ff;

endmodule

/* sv/rv32im_checker.sv */
// Port-level checker for the RV32IM execute block and its bind.
module rv32im_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  rv32im_pkg::req_type  req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rv32im_pkg::rsp_type  rsp_data
);
   import rv32im_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");

   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.mem_read && rsp_data.mem_write))
      else $error("load and store together");

   a_inv_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_INVALID |->
         rsp_data.wb_reg == 5'd0 && !rsp_data.mem_read && !rsp_data.mem_write)
      else $error("invalid instruction had side effects");

endmodule

bind rv32im_instruction_execute_top rv32im_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* dv/rv32im_exec_checker.sv */
// Transaction checker for the RV32IM execute block: predicts each result and compares it.
module rv32im_exec_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  rv32im_pkg::req_type  req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rv32im_pkg::rsp_type  rsp_data,
   input  logic                 csr_we,
   input  logic [31:0]          csr_wdata,
   output int                   error_count,
   output int                   results_waiting,
   output int                   items_seen,
   output int                   loads_returned
);
   import rv32im_pkg::*;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_SLT = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SR = 3'd5;
   localparam logic [2:0] F3_OR = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;

   localparam logic [2:0] F3_BEQ = 3'd0;
   localparam logic [2:0] F3_BNE = 3'd1;
   localparam logic [2:0] F3_BLT = 3'd4;
   localparam logic [2:0] F3_BGE = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_MUL = 3'd0;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU = 3'd3;
   localparam logic [2:0] F3_DIV = 3'd4;
   localparam logic [2:0] F3_DIVU = 3'd5;
   localparam logic [2:0] F3_REM = 3'd6;
   localparam logic [2:0] F3_REMU = 3'd7;

   localparam logic [2:0] F3_LB = 3'd0;
   localparam logic [2:0] F3_LH = 3'd1;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;
   localparam logic [2:0] F3_CSRRW = 3'd1;
   localparam logic [2:0] F3_CSRRS = 3'd2;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT = 7'h20;
   localparam logic [6:0] F7_MEXT = 7'h01;

   logic [31:0] xreg [32];
   logic [31:0] pc_q, mtvec_q, mstatus_q, mepc_q, mcause_q, boot_vector;
   logic [8:0]  load_slot;
   rsp_type     expected_results [$];

   initial begin
      boot_vector = RESET_VECTOR_DEFAULT;
      error_count = 0;
      items_seen = 0;
      loads_returned = 0;
      results_waiting = 0;
   end

   function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
      logic [31:0] t;
      t = v << (32 - bits);
      return $signed(t) >>> (32 - bits);
   endfunction

   function automatic logic [31:0] mul_div(input logic [2:0] f3, input logic [31:0] a,
                                           input logic [31:0] b);
      logic signed [63:0] sa, sb, sp;
      logic [63:0] up;
      logic        ovf;
      sa = {{32{a[31]}}, a};
      sb = {{32{b[31]}}, b};
      ovf = (a == 32'h8000_0000) && (b == 32'hFFFF_FFFF);
      case (f3)
         F3_MUL: return a * b;
         F3_MULH: begin
            sp = sa * sb;
            return sp[63:32];
         end
         F3_MULHSU: begin
            sp = sa * $signed({32'b0, b});
            return sp[63:32];
         end
         F3_MULHU: begin
            up = {32'b0, a} * {32'b0, b};
            return up[63:32];
         end
         F3_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
         F3_REMU: return (b == 0) ? a : a % b;
         F3_DIV: begin
            if (b == 0) return 32'hFFFF_FFFF;
            if (ovf) return a;
            return $signed(a) / $signed(b);
         end
         default: begin
            if (b == 0) return a;
            if (ovf) return 32'h0;
            return $signed(a) % $signed(b);
         end
      endcase
   endfunction

   task automatic predict_execution(input req_type item, output rsp_type res);
      logic [31:0] w, a, b, ii, is, ib, ij, rd_val, npc, old_val, data;
      logic [6:0]  op, f7;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [11:0] csr_num;
      logic        wr, ok, taken;
      w = item.instr_word;
      op = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      rd = w[11:7];
      csr_num = w[31:20];
      a = xreg[w[19:15]];
      b = xreg[w[24:20]];
      ii = sext({20'b0, w[31:20]}, 12);
      is = sext({20'b0, w[31:25], w[11:7]}, 12);
      ib = sext({19'b0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
      ij = sext({11'b0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
      res = '0;
      res.next_pc = pc_q;
      if (item.opcode == REQ_LOAD_RET) begin
         if (load_slot[8]) begin
            case (load_slot[7:5])
               F3_LB: data = sext(item.load_data, 8);
               F3_LH: data = sext(item.load_data, 16);
               F3_LBU: data = item.load_data & 32'hFF;
               F3_LHU: data = item.load_data & 32'hFFFF;
               default: data = item.load_data;
            endcase
            rd = load_slot[4:0];
            load_slot = '0;
            loads_returned++;
            if (rd != 0) begin
               xreg[rd] = data;
               res.wb_reg = rd;
               res.wb_value = data;
            end
         end
         return;
      end
      if (load_slot[8]) return;

      npc = pc_q + 4;
      rd_val = '0;
      wr = 1'b0;
      ok = 1'b1;
      taken = 1'b0;
      case (op)
         OP_LUI: begin
            rd_val = {w[31:12], 12'b0};
            wr = 1'b1;
         end
         OP_AUIPC: begin
            rd_val = pc_q + {w[31:12], 12'b0};
            wr = 1'b1;
         end
         OP_JAL: begin
            rd_val = pc_q + 4;
            wr = 1'b1;
            npc = pc_q + ij;
         end
         OP_JALR: begin
            if (f3 != 0) ok = 1'b0;
            else begin
               rd_val = pc_q + 4;
               wr = 1'b1;
               npc = (a + ii) & ~32'h1;
            end
         end
         OP_BRANCH: begin
            case (f3)
               F3_BEQ: taken = a == b;
               F3_BNE: taken = a != b;
               F3_BLT: taken = $signed(a) < $signed(b);
               F3_BGE: taken = $signed(a) >= $signed(b);
               F3_BLTU: taken = a < b;
               F3_BGEU: taken = a >= b;
               default: ok = 1'b0;
            endcase
            if (taken) npc = pc_q + ib;
         end
         OP_LOAD: begin
            if (f3 == 3 || f3 > 5) ok = 1'b0;
            else begin
               res.mem_read = 1'b1;
               res.mem_addr = a + ii;
               res.mem_size = f3[1:0];
               load_slot = {1'b1, f3, rd};
            end
         end
         OP_STORE: begin
            if (f3 > 2) ok = 1'b0;
            else begin
               res.mem_write = 1'b1;
               res.mem_addr = a + is;
               res.mem_size = f3[1:0];
               res.mem_wdata = (f3 == 0) ? (b & 32'hFF) : (f3 == 1) ? (b & 32'hFFFF) : b;
            end
         end
         OP_IMM: begin
            wr = 1'b1;
            case (f3)
               F3_ADD: rd_val = a + ii;
               F3_SLT: rd_val = ($signed(a) < $signed(ii)) ? 1 : 0;
               F3_SLTU: rd_val = (a < ii) ? 1 : 0;
               F3_XOR: rd_val = a ^ ii;
               F3_OR: rd_val = a | ii;
               F3_AND: rd_val = a & ii;
               F3_SLL: begin
                  if (f7 == F7_BASE) rd_val = a << ii[4:0];
                  else ok = 1'b0;
               end
               default: begin
                  if (f7 == F7_BASE) rd_val = a >> ii[4:0];
                  else if (f7 == F7_ALT) rd_val = $signed(a) >>> ii[4:0];
                  else ok = 1'b0;
               end
            endcase
         end
         OP_REG: begin
            wr = 1'b1;
            if (f7 == F7_MEXT) rd_val = mul_div(f3, a, b);
            else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD) rd_val = a - b;
               else if (f3 == F3_SR) rd_val = $signed(a) >>> b[4:0];
               else ok = 1'b0;
            end else if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD: rd_val = a + b;
                  F3_SLL: rd_val = a << b[4:0];
                  F3_SLT: rd_val = ($signed(a) < $signed(b)) ? 1 : 0;
                  F3_SLTU: rd_val = (a < b) ? 1 : 0;
                  F3_XOR: rd_val = a ^ b;
                  F3_SR: rd_val = a >> b[4:0];
                  F3_OR: rd_val = a | b;
                  default: rd_val = a & b;
               endcase
            end else ok = 1'b0;
         end
         OP_SYSTEM: begin
            if (f3 == F3_CSRRW || f3 == F3_CSRRS) begin
               case (csr_num)
                  CSR_MTVEC: old_val = mtvec_q;
                  CSR_MSTATUS: old_val = mstatus_q;
                  CSR_MEPC: old_val = mepc_q;
                  CSR_MCAUSE: old_val = mcause_q;
                  default: old_val = '0;
               endcase
               data = (f3 == F3_CSRRW) ? a : (old_val | a);
               case (csr_num)
                  CSR_MTVEC: mtvec_q = data;
                  CSR_MSTATUS: mstatus_q = data;
                  CSR_MEPC: mepc_q = data;
                  CSR_MCAUSE: mcause_q = data;
                  default: ;
               endcase
               rd_val = old_val;
               wr = 1'b1;
            end else if (w == INSTR_ECALL) begin
               mepc_q = pc_q + 4;
               mcause_q = xreg[REG_A7];
               npc = mtvec_q;
            end else if (w == INSTR_MRET) begin
               npc = mepc_q;
            end else if (w == INSTR_EBREAK) begin
               res.status = STATUS_HALT;
               res.halt_code = xreg[REG_A0];
            end else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase

      if (!ok) begin
         res = '0;
         res.status = STATUS_INVALID;
         npc = pc_q + 4;
         wr = 1'b0;
      end
      if (wr && rd != 0) begin
         xreg[rd] = rd_val;
         res.wb_reg = rd;
         res.wb_value = rd_val;
      end
      pc_q = npc;
      res.next_pc = npc;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         if (error_count < 10)
            $display("MISMATCH %s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : track
      rsp_type predicted, want;
      if (reset) begin
         foreach (xreg[i]) xreg[i] = '0;
         pc_q = boot_vector;
         mtvec_q = '0;
         mstatus_q = '0;
         mepc_q = '0;
         mcause_q = '0;
         load_slot = '0;
         expected_results.delete();
      end else begin
         if (csr_we) boot_vector = csr_wdata;
         if (req_valid && req_ready) begin
            predict_execution(req_data, predicted);
            expected_results.push_back(predicted);
            items_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (error_count < 10) $display("MISMATCH: result with none expected");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("next_pc", want.next_pc, rsp_data.next_pc);
               compare_field("mem_read", want.mem_read, rsp_data.mem_read);
               compare_field("mem_write", want.mem_write, rsp_data.mem_write);
               compare_field("mem_addr", want.mem_addr, rsp_data.mem_addr);
               compare_field("mem_size", want.mem_size, rsp_data.mem_size);
               compare_field("mem_wdata", want.mem_wdata, rsp_data.mem_wdata);
               compare_field("status", want.status, rsp_data.status);
               compare_field("halt_code", want.halt_code, rsp_data.halt_code);
               compare_field("wb_reg", want.wb_reg, rsp_data.wb_reg);
               compare_field("wb_value", want.wb_value, rsp_data.wb_value);
            end
         end
      end
      results_waiting <= expected_results.size();
   end

   final begin
   end

endmodule

/* dv/rv32im_instruction_execute_top_tb.sv */
// Testbench top for the RV32IM execute block: clock, reset, stimulus and verdict.
module rv32im_instruction_execute_top_tb;
   import rv32im_pkg::*;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SR = 3'd5;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_LB = 3'd0;
   localparam logic [2:0] F3_LHU = 3'd5;
   localparam logic [2:0] F3_DIV = 3'd4;
   localparam logic [2:0] F3_DIVU = 3'd5;
   localparam logic [2:0] F3_REM = 3'd6;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU = 3'd3;
   localparam logic [2:0] F3_CSRRW = 3'd1;
   localparam logic [2:0] F3_CSRRS = 3'd2;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT = 7'h20;
   localparam logic [6:0] F7_MEXT = 7'h01;
   localparam int PHASE_ITEMS = 190;

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready, csr_we;
   logic [31:0] csr_wdata;
   req_type     req_data;
   rsp_type     rsp_data;
   int          error_count, results_waiting, items_seen, loads_returned;
   int          burst_left, stall_timer;
   logic [1:0]  stall_mode;
   bit          load_open;

   rv32im_instruction_execute_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   rv32im_exec_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .error_count(error_count), .results_waiting(results_waiting),
      .items_seen(items_seen), .loads_returned(loads_returned)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         stall_timer <= $urandom_range(20, 120);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_timer % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
   endfunction

   function automatic logic [11:0] pick_imm();
      case ($urandom_range(0, 7))
         0: return 12'h000;
         1: return 12'hFFF;
         2: return 12'h7FF;
         3: return 12'h800;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_instr(output bit is_load);
      logic [11:0] imm, csr_num;
      logic [2:0]  f3;
      logic [31:0] j;
      is_load = 0;
      imm = pick_imm();
      j = $urandom;
      case ($urandom_range(0, 19))
         0: return {j[31:12], pick_reg(), OP_LUI};
         1: return {j[31:12], pick_reg(), OP_AUIPC};
         2: return {j[31:12], pick_reg(), OP_JAL};
         3: return i_type(imm, pick_reg(), ($urandom_range(0, 9) == 0) ? 3'($urandom) : F3_ADD,
                          pick_reg(), OP_JALR);
         4, 5: return {j[31:25], pick_reg(), pick_reg(), 3'($urandom), j[11:7], OP_BRANCH};
         6, 7: begin
            case ($urandom_range(0, 5))
               0: f3 = 3'd0;
               1: f3 = 3'd1;
               2: f3 = 3'd2;
               3: f3 = 3'd4;
               4: f3 = 3'd5;
               default: f3 = 3'($urandom);
            endcase
            is_load = !(f3 == 3 || f3 > 5);
            return i_type(imm, pick_reg(), f3, pick_reg(), OP_LOAD);
         end
         8: return {j[31:25], pick_reg(), pick_reg(), 3'($urandom_range(0, 3)), j[11:7], OP_STORE};
         9, 10, 19: begin
            f3 = 3'($urandom);
            if (f3 == 1 || f3 == F3_SR)
               imm[11:5] = ($urandom_range(0, 9) == 0) ? 7'($urandom)
                         : ($urandom_range(0, 1) ? F7_ALT : F7_BASE);
            return i_type(imm, pick_reg(), f3, pick_reg(), OP_IMM);
         end
         11, 12: return r_type(($urandom_range(0, 9) == 0) ? 7'($urandom)
                               : ($urandom_range(0, 1) ? F7_ALT : F7_BASE),
                               pick_reg(), pick_reg(), 3'($urandom), pick_reg(), OP_REG);
         13, 14: return r_type(F7_MEXT, pick_reg(), pick_reg(), 3'($urandom), pick_reg(), OP_REG);
         15: begin
            case ($urandom_range(0, 4))
               0: csr_num = CSR_MTVEC;
               1: csr_num = CSR_MSTATUS;
               2: csr_num = CSR_MEPC;
               3: csr_num = CSR_MCAUSE;
               default: csr_num = 12'($urandom);
            endcase
            return i_type(csr_num, pick_reg(), $urandom_range(0, 1) ? F3_CSRRW : F3_CSRRS,
                          pick_reg(), OP_SYSTEM);
         end
         16: begin
            case ($urandom_range(0, 2))
               0: return INSTR_ECALL;
               1: return INSTR_MRET;
               default: return INSTR_EBREAK;
            endcase
         end
         17: return $urandom;
         default: return i_type(imm, pick_reg(), 3'($urandom), pick_reg(), OP_SYSTEM);
      endcase
   endfunction

   task automatic issue(input req_type item);
      int gap;
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 15);
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   task automatic write_boot_vector(input logic [31:0] value);
      drain();
      repeat (60) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic issue_exec(input logic [31:0] w);
      req_type item;
      item.opcode = REQ_EXEC;
      item.instr_word = w;
      item.load_data = $urandom;
      issue(item);
   endtask

   task automatic issue_return(input logic [31:0] d);
      req_type item;
      item.opcode = REQ_LOAD_RET;
      item.instr_word = $urandom;
      item.load_data = d;
      issue(item);
   endtask

   task automatic random_phase();
      logic [31:0] w;
      bit is_load;
      repeat (PHASE_ITEMS) begin
         if (load_open && $urandom_range(0, 99) < 85) begin
            issue_return(pick_data());
            load_open = 0;
         end else if (!load_open && $urandom_range(0, 99) < 4) begin
            issue_return(pick_data());
         end else begin
            w = random_instr(is_load);
            if (is_load) load_open = 1;
            issue_exec(w);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      rsp_ready <= 1'b0;
      stall_timer = 0;
      stall_mode = 2'd0;
      burst_left = 0;
      load_open = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_boot_vector($urandom);
      issue_exec({20'h80000, 5'd1, OP_LUI});
      issue_exec(i_type(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));
      issue_exec(r_type(F7_MEXT, 5'd2, 5'd1, F3_DIV, 5'd3, OP_REG));
      issue_exec(r_type(F7_MEXT, 5'd2, 5'd1, F3_REM, 5'd4, OP_REG));
      issue_exec(r_type(F7_MEXT, 5'd0, 5'd1, F3_DIVU, 5'd5, OP_REG));
      issue_exec(r_type(F7_MEXT, 5'd0, 5'd2, F3_REM, 5'd6, OP_REG));
      issue_exec(r_type(F7_MEXT, 5'd2, 5'd2, F3_MULHSU, 5'd7, OP_REG));
      issue_exec(r_type(F7_MEXT, 5'd1, 5'd1, F3_MULH, 5'd8, OP_REG));
      issue_exec(r_type(F7_MEXT, 5'd2, 5'd2, F3_MULHU, 5'd9, OP_REG));
      issue_exec(r_type(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd11, OP_REG));
      issue_exec(i_type({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd12, OP_IMM));
      issue_exec(i_type(CSR_MTVEC, 5'd1, F3_CSRRW, 5'd13, OP_SYSTEM));
      issue_exec(i_type(12'd11, 5'd0, F3_ADD, REG_A7, OP_IMM));
      issue_exec(INSTR_ECALL);
      issue_exec(INSTR_MRET);
      issue_exec(i_type(CSR_MEPC, 5'd0, F3_CSRRS, 5'd14, OP_SYSTEM));
      issue_exec(i_type(12'h7C0, 5'd2, F3_CSRRS, 5'd15, OP_SYSTEM));
      issue_exec(INSTR_EBREAK);
      issue_exec(i_type(12'h000, 5'd2, F3_LB, 5'd16, OP_LOAD));
      issue_return(32'h0000_0080);
      issue_exec(i_type(12'h7FF, 5'd1, F3_LHU, 5'd0, OP_LOAD));
      issue_exec(i_type(12'd1, 5'd0, F3_ADD, 5'd18, OP_IMM));
      issue_return(32'hFFFF_FFFF);
      issue_return(32'h1234_5678);
      issue_exec({7'h0, 5'd2, 5'd1, F3_WORD, 5'd4, OP_STORE});
      issue_exec(i_type(12'hFFF, 5'd2, F3_ADD, 5'd1, OP_JALR));
      issue_exec(32'hFFFF_FFFF);

      write_boot_vector(32'h0000_0000);
      random_phase();
      write_boot_vector(32'hFFFF_FFFF);
      random_phase();
      drain();
      random_phase();
      write_boot_vector($urandom);
      random_phase();
      write_boot_vector(RESET_VECTOR_DEFAULT);

      drain();
      repeat (60) @(posedge clock);
      $display("Run covered %0d transactions, %0d load returns, five reset-vector settings,",
               items_seen, loads_returned);
      $display("with bursty input and shifting output stalls.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
